// ===== rtl/core/dslt_pkg.sv =====
`timescale 1ns / 1ps

package dslt_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int HANDLE_BITS = 16;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int OP_W        = 3;
  localparam int FD_W        = 7;
  localparam int ST_W        = 2;
  localparam int FD_OUT_W    = 6;

  // free-slot search tree: groups of eight slots
  localparam int GRP_SIZE  = 8;
  localparam int GRP_W     = $clog2(GRP_SIZE);
  localparam int GRP_COUNT = SLOT_COUNT / GRP_SIZE;
  localparam int GRP_SEL_W = $clog2(GRP_COUNT);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_CLOSE     = 3'd1,
    OP_GET       = 3'd2,
    OP_DUP       = 3'd3,
    OP_DUP2      = 3'd4,
    OP_CLOSE_ALL = 3'd5
  } op_t;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    A_IN   = 2'd0,
    A_NFD  = 2'd1,
    A_SCAN = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      accept;
    logic      ram_re;
    addr_sel_t addr_sel;
    logic      latch_src;
    logic      exec_load;
    logic      emit_load;
    logic      scan_inc;
  } cmd_t;

  typedef struct packed {
    logic any_used;
    logic scan_used;
    logic scan_final;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/dslt_ram.sv =====
`timescale 1ns / 1ps

module dslt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/dslt_ctrl.sv =====
`timescale 1ns / 1ps

module dslt_ctrl
  import dslt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_opcode,
  output logic            in_ready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD2  = 5'b00010,
    S_EXEC = 5'b00100,
    S_SCAN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = A_IN;
    state_nxt    = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.ram_re = in_valid;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (in_opcode == OP_DUP2) begin
            state_nxt = S_RD2;
          end else if (in_opcode == OP_CLOSE_ALL && sts.any_used) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_RD2: begin
        cmd.addr_sel  = A_NFD;
        cmd.ram_re    = 1'b1;
        cmd.latch_src = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.addr_sel = A_SCAN;
        if (sts.scan_used) begin
          cmd.ram_re = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.addr_sel = A_SCAN;
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.scan_inc  = 1'b1;
          state_nxt     = sts.scan_final ? S_IDLE : S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== rtl/core/dslt_dp.sv =====
`timescale 1ns / 1ps

module dslt_dp
  import dslt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [OP_W-1:0]        in_opcode,
  input  logic [FD_W-1:0]        in_fd,
  input  logic [FD_W-1:0]        in_new_fd,
  input  logic [HANDLE_BITS-1:0] in_handle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ST_W-1:0]        out_status,
  output logic [FD_OUT_W-1:0]    out_fd_out,
  output logic [HANDLE_BITS-1:0] out_handle_out,
  output logic                   out_take_ref,
  output logic [HANDLE_BITS-1:0] out_drop_handle,
  output logic                   out_last
);

  logic [OP_W-1:0]        op_r;
  logic [FD_W-1:0]        fd_r;
  logic [FD_W-1:0]        nfd_r;
  logic [HANDLE_BITS-1:0] h_r;
  logic [HANDLE_BITS-1:0] src_r;
  logic [SLOT_W-1:0]      idx_r;
  logic [SLOT_COUNT-1:0]  used_r;
  logic [SLOT_COUNT-1:0]  used_nxt;
  logic [GRP_COUNT-1:0]   grp_any_r;
  logic [GRP_COUNT-1:0]   grp_any_nxt;
  logic [GRP_W-1:0]       grp_idx_r   [GRP_COUNT];
  logic [GRP_W-1:0]       grp_idx_nxt [GRP_COUNT];

  logic                   out_valid_r;
  logic [ST_W-1:0]        st_r;
  logic [FD_OUT_W-1:0]    fdo_r;
  logic [HANDLE_BITS-1:0] ho_r;
  logic                   take_r;
  logic [HANDLE_BITS-1:0] drop_r;
  logic                   last_r;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [HANDLE_BITS-1:0] ram_wdata;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [HANDLE_BITS-1:0] ram_rdata;

  logic [GRP_SEL_W-1:0]   free_grp;
  logic                   free_any;
  logic [SLOT_W-1:0]      free_idx;
  logic [SLOT_COUNT-1:0]  rest_used;

  logic [HANDLE_BITS-1:0] src_h;
  logic [SLOT_W-1:0]      fd_idx;
  logic [SLOT_W-1:0]      nfd_idx;
  logic                   fd_ok;
  logic                   nfd_ok;
  logic                   src_used;
  logic                   dst_used;
  logic [ST_W-1:0]        x_st;
  logic [FD_OUT_W-1:0]    x_fdo;
  logic [HANDLE_BITS-1:0] x_ho;
  logic                   x_take;
  logic [HANDLE_BITS-1:0] x_drop;
  logic                   x_wr;
  logic [SLOT_W-1:0]      x_waddr;
  logic [HANDLE_BITS-1:0] x_wdata;
  logic                   x_set;
  logic                   x_clr;
  logic [SLOT_W-1:0]      x_slot;

  dslt_ram #(
    .WIDTH(HANDLE_BITS),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (cmd.addr_sel)
      A_IN:    ram_raddr = in_fd[SLOT_W-1:0];
      A_NFD:   ram_raddr = nfd_r[SLOT_W-1:0];
      A_SCAN:  ram_raddr = idx_r;
      default: ram_raddr = in_fd[SLOT_W-1:0];
    endcase
  end

  // first level of the free-slot tree, registered
  always_comb begin
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_any_nxt[g] = ~&used_r[g*GRP_SIZE +: GRP_SIZE];
      grp_idx_nxt[g] = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (!used_r[g*GRP_SIZE + b]) begin
          grp_idx_nxt[g] = GRP_W'(b);
        end
      end
    end
  end

  always_comb begin
    free_grp = '0;
    for (int g = GRP_COUNT - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        free_grp = GRP_SEL_W'(g);
      end
    end
    free_any = |grp_any_r;
    free_idx = {free_grp, grp_idx_r[free_grp]};
  end

  always_comb begin
    rest_used         = used_r;
    rest_used[idx_r]  = 1'b0;
  end

  always_comb begin
    fd_idx   = fd_r[SLOT_W-1:0];
    nfd_idx  = nfd_r[SLOT_W-1:0];
    fd_ok    = 32'(fd_r) < SLOT_COUNT;
    nfd_ok   = 32'(nfd_r) < SLOT_COUNT;
    src_used = fd_ok && used_r[fd_idx];
    dst_used = used_r[nfd_idx];
    src_h    = (op_r == OP_DUP2) ? src_r : ram_rdata;
    x_st     = ST_OK;
    x_fdo    = '0;
    x_ho     = '0;
    x_take   = 1'b0;
    x_drop   = '0;
    x_wr     = 1'b0;
    x_waddr  = free_idx;
    x_wdata  = src_h;
    x_set    = 1'b0;
    x_clr    = 1'b0;
    x_slot   = free_idx;
    case (op_r)
      OP_ALLOC: begin
        if (h_r == '0) begin
          x_st = ST_BAD;
        end else if (!free_any) begin
          x_st = ST_FULL;
        end else begin
          x_fdo   = FD_OUT_W'(free_idx);
          x_wr    = 1'b1;
          x_wdata = h_r;
          x_set   = 1'b1;
        end
      end
      OP_CLOSE: begin
        if (!src_used) begin
          x_st = ST_BAD;
        end else begin
          x_drop = src_h;
          x_clr  = 1'b1;
          x_slot = fd_idx;
        end
      end
      OP_GET: begin
        if (!src_used) begin
          x_st = ST_BAD;
        end else begin
          x_ho   = src_h;
          x_take = 1'b1;
        end
      end
      OP_DUP: begin
        if (!src_used) begin
          x_st = ST_BAD;
        end else if (!free_any) begin
          x_st = ST_FULL;
        end else begin
          x_fdo  = FD_OUT_W'(free_idx);
          x_ho   = src_h;
          x_take = 1'b1;
          x_wr   = 1'b1;
          x_set  = 1'b1;
        end
      end
      OP_DUP2: begin
        if (!src_used || !nfd_ok) begin
          x_st = ST_BAD;
        end else if (dst_used && ram_rdata == src_h) begin
          x_fdo = FD_OUT_W'(nfd_idx);
          x_ho  = src_h;
        end else begin
          x_fdo   = FD_OUT_W'(nfd_idx);
          x_ho    = src_h;
          x_take  = 1'b1;
          x_drop  = dst_used ? ram_rdata : '0;
          x_wr    = 1'b1;
          x_waddr = nfd_idx;
          x_set   = 1'b1;
          x_slot  = nfd_idx;
        end
      end
      OP_CLOSE_ALL: begin
        // only reached with an empty table
        x_st = ST_OK;
      end
      default: begin
        x_st = ST_BAD;
      end
    endcase
  end

  assign ram_we    = cmd.exec_load && x_wr;
  assign ram_waddr = x_waddr;
  assign ram_wdata = x_wdata;

  always_comb begin
    used_nxt = used_r;
    if (cmd.exec_load && x_set) begin
      used_nxt[x_slot] = 1'b1;
    end
    if (cmd.exec_load && x_clr) begin
      used_nxt[x_slot] = 1'b0;
    end
    if (cmd.emit_load) begin
      used_nxt[idx_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
      grp_any_r   <= '1;
      for (int g = 0; g < GRP_COUNT; g++) begin
        grp_idx_r[g] <= '0;
      end
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= (out_valid_r && !out_ready) || cmd.exec_load || cmd.emit_load;
      grp_any_r   <= grp_any_nxt;
      for (int g = 0; g < GRP_COUNT; g++) begin
        grp_idx_r[g] <= grp_idx_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_opcode;
      fd_r  <= in_fd;
      nfd_r <= in_new_fd;
      h_r   <= in_handle;
      idx_r <= '0;
    end else if (cmd.scan_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.latch_src) begin
      src_r <= ram_rdata;
    end
    if (cmd.exec_load) begin
      st_r   <= x_st;
      fdo_r  <= x_fdo;
      ho_r   <= x_ho;
      take_r <= x_take;
      drop_r <= x_drop;
      last_r <= 1'b1;
    end else if (cmd.emit_load) begin
      st_r   <= ST_OK;
      fdo_r  <= '0;
      ho_r   <= '0;
      take_r <= 1'b0;
      drop_r <= ram_rdata;
      last_r <= ~|rest_used;
    end
  end

  assign sts.any_used   = |used_r;
  assign sts.scan_used  = used_r[idx_r];
  assign sts.scan_final = ~|rest_used;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = st_r;
  assign out_fd_out      = fdo_r;
  assign out_handle_out  = ho_r;
  assign out_take_ref    = take_r;
  assign out_drop_handle = drop_r;
  assign out_last        = last_r;

endmodule

// ===== rtl/core/descriptor_slot_table.sv =====
`timescale 1ns / 1ps
// channel  | handshake            | word
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | in_opcode, in_fd, in_new_fd, in_handle
// out      | out_valid / out_ready| out_status, out_fd_out, out_handle_out,
//          |                      | out_take_ref, out_drop_handle, out_last
//
// Steps: accept, execute; dup2 reads in between, one read port fetching source
// then target. Close all: accept, then a scan step per empty slot, a scan and an
// emit step per occupied one up to the highest; on an empty table accept, execute.
// Reset: occupancy flags clear at once; the handle memory is never cleared.
// Stalls: results wait in the output register; the next word is accepted
// meanwhile and its execute cycle holds until that register is free.

module descriptor_slot_table
  import dslt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        in_opcode,
  input  logic [FD_W-1:0]        in_fd,
  input  logic [FD_W-1:0]        in_new_fd,
  input  logic [HANDLE_BITS-1:0] in_handle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ST_W-1:0]        out_status,
  output logic [FD_OUT_W-1:0]    out_fd_out,
  output logic [HANDLE_BITS-1:0] out_handle_out,
  output logic                   out_take_ref,
  output logic [HANDLE_BITS-1:0] out_drop_handle,
  output logic                   out_last
);

  cmd_t cmd;
  sts_t sts;

  dslt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dslt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_fd          (in_fd),
    .in_new_fd      (in_new_fd),
    .in_handle      (in_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_fd_out     (out_fd_out),
    .out_handle_out (out_handle_out),
    .out_take_ref   (out_take_ref),
    .out_drop_handle(out_drop_handle),
    .out_last       (out_last)
  );

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while previous one still executing");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_fd_out == '0 && out_handle_out == '0 && !out_take_ref &&
       out_drop_handle == '0 && out_last))
    else $error("error result carries payload");

  a_take_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_take_ref) |-> (out_handle_out != '0))
    else $error("reference taken on empty handle");

  a_scan_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_drop_handle != '0 && out_status == ST_OK))
    else $error("close-all result without dropped handle");

endmodule
